// ===== rtl/af_packet_tag_parser_top_assert.svh =====
// Assertion macros for the AF packet tag parser.
`ifndef AF_PACKET_TAG_PARSER_TOP_ASSERT_SVH
`define AF_PACKET_TAG_PARSER_TOP_ASSERT_SVH

`ifndef SYNTH

// Same-cycle implication, checked outside reset.
`define AFTP_ASSERT_IMP(label, clk, rst_n, pre, con) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (con)) \
		else $error("aftp assertion failed");

// Next-cycle implication, checked outside reset.
`define AFTP_ASSERT_NXT(label, clk, rst_n, pre, con) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (con)) \
		else $error("aftp assertion failed");

`else

`define AFTP_ASSERT_IMP(label, clk, rst_n, pre, con)
`define AFTP_ASSERT_NXT(label, clk, rst_n, pre, con)

`endif

`endif

// ===== rtl/aftp_pkg.sv =====
// Shared types, codes and constants of the AF packet tag parser.
package aftp_pkg;

	localparam int unsigned TRAILER_BYTES_DEF = 2;

	localparam logic [7:0] CHAR_A = 8'h41;
	localparam logic [7:0] CHAR_F = 8'h46;
	localparam logic [7:0] CHAR_T = 8'h54;

	localparam logic [3:0] OFF_SYNC_A = 4'd0;
	localparam logic [3:0] OFF_SYNC_F = 4'd1;
	localparam logic [3:0] OFF_SEQ_HI = 4'd6;
	localparam logic [3:0] OFF_SEQ_LO = 4'd7;
	localparam logic [3:0] OFF_FLAGS  = 4'd8;
	localparam logic [3:0] OFF_TYPE   = 4'd9;

	localparam logic [28:0] FIELD_LAST_BYTE = 29'd3;

	localparam logic [1:0] KIND_HEADER  = 2'd0;
	localparam logic [1:0] KIND_PAYLOAD = 2'd1;
	localparam logic [1:0] KIND_STATUS  = 2'd2;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_BAD_SYNC  = 3'd1;
	localparam logic [2:0] ST_BAD_TYPE  = 3'd2;
	localparam logic [2:0] ST_TOO_SHORT = 3'd3;
	localparam logic [2:0] ST_TRUNCATED = 3'd4;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] tag_name;
		logic [28:0] tag_length;
		logic [7:0]  payload_byte;
		logic        tag_end;
		logic [2:0]  status;
		logic [15:0] sequence_res;
		logic [7:0]  header_flags;
		logic        final_of_step;
	} result_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] data;
		logic       last;
	} pop_t;

	typedef struct packed {
		logic    first_valid;
		result_t first;
		logic    second_valid;
		result_t second;
	} result_pair_t;

endpackage

// ===== rtl/aftp_byte_if.sv =====
// Valid/ready channel that carries one frame byte per transfer.
interface aftp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       frame_end;

	modport source (output valid, output data_byte, output frame_end, input ready);
	modport sink (input valid, input data_byte, input frame_end, output ready);
endinterface

// ===== rtl/aftp_result_if.sv =====
// Valid/ready channel that carries one parser result per transfer.
interface aftp_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [31:0] tag_name;
	logic [28:0] tag_length;
	logic [7:0]  payload_byte;
	logic        tag_end;
	logic [2:0]  status;
	logic [15:0] sequence_res;
	logic [7:0]  header_flags;
	logic        final_of_step;

	modport source (
		output valid, output kind, output tag_name, output tag_length, output payload_byte,
		output tag_end, output status, output sequence_res, output header_flags,
		output final_of_step, input ready
	);
	modport sink (
		input valid, input kind, input tag_name, input tag_length, input payload_byte,
		input tag_end, input status, input sequence_res, input header_flags,
		input final_of_step, output ready
	);
endinterface

// ===== rtl/aftp_delay.sv =====
// Trailer delay line that holds back the last bytes of every frame.
module aftp_delay #(
	parameter int unsigned TRAILER_BYTES = aftp_pkg::TRAILER_BYTES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step,
	input  logic [7:0]     data_in,
	input  logic           last,
	output aftp_pkg::pop_t pop
);

	assign pop.last = last;

	if (TRAILER_BYTES == 0) begin : g_direct
		assign pop.valid = 1'b1;
		assign pop.data  = data_in;
	end else begin : g_line
		localparam int FILL_W = $clog2(TRAILER_BYTES + 1);
		localparam int IDX_W  = (TRAILER_BYTES > 1) ? $clog2(TRAILER_BYTES) : 1;

		logic [7:0]        line_q [TRAILER_BYTES];
		logic [FILL_W-1:0] fill_q;
		logic              full;

		assign full      = (fill_q == FILL_W'(TRAILER_BYTES));
		assign pop.valid = full;
		assign pop.data  = line_q[0];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				fill_q <= '0;
			end else if (step) begin
				if (last) begin
					fill_q <= '0;
				end else if (!full) begin
					fill_q <= fill_q + FILL_W'(1);
				end
			end
		end

		always_ff @(posedge clk) begin
			if (step) begin
				if (full) begin
					for (int i = 0; i < int'(TRAILER_BYTES) - 1; i++) begin
						line_q[i] <= line_q[i + 1];
					end
					line_q[TRAILER_BYTES - 1] <= data_in;
				end else begin
					line_q[fill_q[IDX_W-1:0]] <= data_in;
				end
			end
		end
	end

endmodule

// ===== rtl/aftp_parse.sv =====
// Frame header check, tag item split and frame status generation.
module aftp_parse (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  aftp_pkg::pop_t         pop,
	output aftp_pkg::result_pair_t pair
);

	typedef enum logic [4:0] {
		PH_HDR  = 5'b00001,
		PH_NAME = 5'b00010,
		PH_LEN  = 5'b00100,
		PH_PAY  = 5'b01000,
		PH_SKIP = 5'b10000
	} phase_t;

	phase_t      phase_q, phase_n;
	logic [3:0]  off_q, off_n;
	logic [28:0] count_q, count_n;
	logic [31:0] name_q, name_n;
	logic [31:0] len_q, len_n;
	logic [15:0] seq_q, seq_n;
	logic [7:0]  flags_q, flags_n;
	logic [2:0]  err_q, err_n;
	logic [31:0] len_shifted;
	logic [28:0] len_new;
	logic [28:0] len_held;
	logic [2:0]  st;

	assign len_shifted = {len_q[23:0], pop.data};
	assign len_new     = len_shifted[31:3];
	assign len_held    = len_q[31:3];

	always_comb begin
		phase_n = phase_q;
		off_n   = off_q;
		count_n = count_q;
		name_n  = name_q;
		len_n   = len_q;
		seq_n   = seq_q;
		flags_n = flags_q;
		err_n   = err_q;
		pair.first_valid = 1'b0;
		pair.first       = '0;
		if (pop.valid) begin
			unique case (phase_q)
				PH_HDR: begin
					off_n = off_q + 4'd1;
					if ((off_q == aftp_pkg::OFF_SYNC_A && pop.data != aftp_pkg::CHAR_A) ||
					    (off_q == aftp_pkg::OFF_SYNC_F && pop.data != aftp_pkg::CHAR_F)) begin
						err_n   = aftp_pkg::ST_BAD_SYNC;
						phase_n = PH_SKIP;
					end else if (off_q == aftp_pkg::OFF_SEQ_HI) begin
						seq_n[15:8] = pop.data;
					end else if (off_q == aftp_pkg::OFF_SEQ_LO) begin
						seq_n[7:0] = pop.data;
					end else if (off_q == aftp_pkg::OFF_FLAGS) begin
						flags_n = pop.data;
					end else if (off_q == aftp_pkg::OFF_TYPE) begin
						if (pop.data != aftp_pkg::CHAR_T) begin
							err_n   = aftp_pkg::ST_BAD_TYPE;
							phase_n = PH_SKIP;
						end else begin
							phase_n = PH_NAME;
							count_n = '0;
						end
					end
				end
				PH_NAME: begin
					name_n = {name_q[23:0], pop.data};
					if (count_q == aftp_pkg::FIELD_LAST_BYTE) begin
						phase_n = PH_LEN;
						count_n = '0;
					end else begin
						count_n = count_q + 29'd1;
					end
				end
				PH_LEN: begin
					len_n = len_shifted;
					if (count_q == aftp_pkg::FIELD_LAST_BYTE) begin
						pair.first_valid        = 1'b1;
						pair.first.kind         = aftp_pkg::KIND_HEADER;
						pair.first.tag_name     = name_q;
						pair.first.tag_length   = len_new;
						pair.first.tag_end      = (len_new == '0);
						if (len_new == '0) begin
							phase_n = PH_NAME;
							count_n = '0;
						end else begin
							phase_n = PH_PAY;
							count_n = len_new;
						end
					end else begin
						count_n = count_q + 29'd1;
					end
				end
				PH_PAY: begin
					pair.first_valid         = 1'b1;
					pair.first.kind          = aftp_pkg::KIND_PAYLOAD;
					pair.first.tag_name      = name_q;
					pair.first.tag_length    = len_held;
					pair.first.payload_byte  = pop.data;
					pair.first.tag_end       = (count_q <= 29'd1);
					if (count_q <= 29'd1) begin
						phase_n = PH_NAME;
						count_n = '0;
					end else begin
						count_n = count_q - 29'd1;
					end
				end
				PH_SKIP: begin
				end
				default: begin
				end
			endcase
		end
		pair.first.final_of_step = !pop.last;

		if (err_n != aftp_pkg::ST_OK) begin
			st = err_n;
		end else if (phase_n == PH_HDR) begin
			st = aftp_pkg::ST_TOO_SHORT;
		end else if (phase_n == PH_NAME && count_n == '0) begin
			st = aftp_pkg::ST_OK;
		end else begin
			st = aftp_pkg::ST_TRUNCATED;
		end
		pair.second_valid         = pop.last;
		pair.second               = '0;
		pair.second.kind          = aftp_pkg::KIND_STATUS;
		pair.second.status        = st;
		pair.second.sequence_res  = seq_n;
		pair.second.header_flags  = flags_n;
		pair.second.final_of_step = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR;
			off_q   <= '0;
			count_q <= '0;
			seq_q   <= '0;
			flags_q <= '0;
			err_q   <= aftp_pkg::ST_OK;
		end else if (step) begin
			if (pop.last) begin
				phase_q <= PH_HDR;
				off_q   <= '0;
				count_q <= '0;
				seq_q   <= '0;
				flags_q <= '0;
				err_q   <= aftp_pkg::ST_OK;
			end else begin
				phase_q <= phase_n;
				off_q   <= off_n;
				count_q <= count_n;
				seq_q   <= seq_n;
				flags_q <= flags_n;
				err_q   <= err_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			name_q <= name_n;
			len_q  <= len_n;
		end
	end

endmodule

// ===== rtl/aftp_outbuf.sv =====
// Two-entry result register that hands results out one transfer at a time.
module aftp_outbuf (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load,
	input  aftp_pkg::result_pair_t pair,
	output logic                   can_take,
	aftp_result_if.source          result
);

	aftp_pkg::result_t e0_q, e1_q;
	logic [1:0]        cnt_q;
	logic              drain;
	logic [1:0]        n_new;

	assign drain    = (cnt_q != 2'd0) && result.ready;
	assign can_take = (cnt_q == 2'd0) || (cnt_q == 2'd1 && result.ready);
	assign n_new    = {1'b0, pair.first_valid} + {1'b0, pair.second_valid};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= n_new;
		end else if (drain) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			e0_q <= pair.first_valid ? pair.first : pair.second;
			e1_q <= pair.second;
		end else if (drain) begin
			e0_q <= e1_q;
		end
	end

	assign result.valid         = (cnt_q != 2'd0);
	assign result.kind          = e0_q.kind;
	assign result.tag_name      = e0_q.tag_name;
	assign result.tag_length    = e0_q.tag_length;
	assign result.payload_byte  = e0_q.payload_byte;
	assign result.tag_end       = e0_q.tag_end;
	assign result.status        = e0_q.status;
	assign result.sequence_res  = e0_q.sequence_res;
	assign result.header_flags  = e0_q.header_flags;
	assign result.final_of_step = e0_q.final_of_step;

endmodule

// ===== rtl/af_packet_tag_parser_top.sv =====
// Top level of the AF packet tag parser.
// The parser takes one frame byte per transfer and keeps up with one byte per
// cycle. A byte enters an input register and then the trailer delay line; the
// byte that leaves the delay line passes the header/tag decision logic into a
// two-entry result register. The final byte of a frame can cause two results
// (the last payload or header result and the frame status); the result
// register drains them one per cycle while the result side is ready, so the
// input stalls there, and otherwise only when the result side stalls. The last
// TRAILER_BYTES bytes of each frame are dropped as the trailer. Status codes:
// 0 ok, 1 bad sync, 2 bad type, 3 too short, 4 truncated item. No clearing
// pass is needed after reset.
`include "af_packet_tag_parser_top_assert.svh"

module af_packet_tag_parser_top #(
	parameter int unsigned TRAILER_BYTES = aftp_pkg::TRAILER_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	aftp_byte_if.sink   frame,
	aftp_result_if.source result
);

	logic                   valid_s1;
	logic [7:0]             data_s1;
	logic                   end_s1;
	logic                   can_take;
	logic                   adv;
	aftp_pkg::pop_t         pop;
	aftp_pkg::result_pair_t pair;

	assign adv         = valid_s1 && can_take;
	assign frame.ready = !valid_s1 || can_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (frame.valid && frame.ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (frame.valid && frame.ready) begin
			data_s1 <= frame.data_byte;
			end_s1  <= frame.frame_end;
		end
	end

	aftp_delay #(
		.TRAILER_BYTES(TRAILER_BYTES)
	) u_delay (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (adv),
		.data_in (data_s1),
		.last    (end_s1),
		.pop     (pop)
	);

	aftp_parse u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv),
		.pop    (pop),
		.pair   (pair)
	);

	aftp_outbuf u_outbuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (adv),
		.pair     (pair),
		.can_take (can_take),
		.result   (result)
	);

	`AFTP_ASSERT_IMP(a_status_final, clk, arst_n, result.valid && result.kind == aftp_pkg::KIND_STATUS, result.final_of_step)
	`AFTP_ASSERT_IMP(a_header_end, clk, arst_n, result.valid && result.kind == aftp_pkg::KIND_HEADER, result.tag_end == (result.tag_length == '0))
	`AFTP_ASSERT_IMP(a_payload_len, clk, arst_n, result.valid && result.kind == aftp_pkg::KIND_PAYLOAD, result.tag_length != '0)
	`AFTP_ASSERT_NXT(a_stall_hold, clk, arst_n, valid_s1 && !can_take, valid_s1 && $stable(data_s1) && $stable(end_s1))

endmodule

// ===== tb/tb_af_packet_tag_parser_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the AF packet tag parser with directed and random frames.
module tb_af_packet_tag_parser_top;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned PHASE_BYTES = 440;
	localparam int unsigned LONG_HOLD = 300;
	localparam int unsigned FIELD_BYTES = 4;
	localparam int unsigned DRAIN_CYCLES = 10;

	typedef enum logic [4:0] {
		AT_HEADER  = 5'b00001,
		AT_NAME    = 5'b00010,
		AT_LENGTH  = 5'b00100,
		AT_PAYLOAD = 5'b01000,
		AT_SKIP    = 5'b10000
	} parse_at_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} frame_byte_t;

	logic clk;
	logic arst_n;

	aftp_byte_if   frame_ch ();
	aftp_result_if result_ch ();

	af_packet_tag_parser_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.frame  (frame_ch),
		.result (result_ch)
	);

	logic [7:0]  trailer_line[$];
	parse_at_t   parse_at;
	logic [3:0]  hdr_index;
	logic [28:0] field_left;
	logic [31:0] name_acc;
	logic [31:0] bitlen_acc;
	logic [15:0] seq_cap;
	logic [7:0]  flags_cap;
	logic [2:0]  error_cap;

	aftp_pkg::result_t expected_results[$];
	frame_byte_t       pending_bytes[$];
	logic [7:0]        frame_buf[$];
	frame_byte_t       next_byte;
	aftp_pkg::result_t seen_res;
	aftp_pkg::result_t want_res;
	logic              byte_taken;

	int unsigned mismatch_count;
	int unsigned gen_count;
	int unsigned cycle_count;
	int unsigned src_idle_pct;
	int unsigned sink_idle_pct;
	int unsigned hold_req_cnt;
	int unsigned hold_seen_cnt;
	int unsigned hold_left;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic clear_frame_state();
		trailer_line.delete();
		parse_at = AT_HEADER;
		hdr_index = '0;
		field_left = '0;
		name_acc = '0;
		bitlen_acc = '0;
		seq_cap = '0;
		flags_cap = '0;
		error_cap = aftp_pkg::ST_OK;
	endtask

	// Runs one frame byte through the trailer delay and the tag item parser.
	task automatic parse_frame_byte(input logic [7:0] in_byte, input logic in_last);
		aftp_pkg::result_t step_out[$];
		aftp_pkg::result_t res;
		logic [7:0]        b;
		logic [28:0]       len;
		int                i;
		trailer_line.push_back(in_byte);
		if (trailer_line.size() > aftp_pkg::TRAILER_BYTES_DEF) begin
			b = trailer_line.pop_front();
			res = '0;
			case (parse_at)
			AT_HEADER: begin
				if ((hdr_index == aftp_pkg::OFF_SYNC_A && b != aftp_pkg::CHAR_A) ||
				    (hdr_index == aftp_pkg::OFF_SYNC_F && b != aftp_pkg::CHAR_F)) begin
					error_cap = aftp_pkg::ST_BAD_SYNC;
					parse_at = AT_SKIP;
				end else if (hdr_index == aftp_pkg::OFF_TYPE && b != aftp_pkg::CHAR_T) begin
					error_cap = aftp_pkg::ST_BAD_TYPE;
					parse_at = AT_SKIP;
				end else begin
					if (hdr_index == aftp_pkg::OFF_SEQ_HI)
						seq_cap[15:8] = b;
					if (hdr_index == aftp_pkg::OFF_SEQ_LO)
						seq_cap[7:0] = b;
					if (hdr_index == aftp_pkg::OFF_FLAGS)
						flags_cap = b;
					if (hdr_index == aftp_pkg::OFF_TYPE) begin
						parse_at = AT_NAME;
						field_left = '0;
						name_acc = '0;
					end
					hdr_index = hdr_index + 4'd1;
				end
			end
			AT_NAME: begin
				name_acc = {name_acc[23:0], b};
				field_left = field_left + 29'd1;
				if (field_left >= FIELD_BYTES) begin
					parse_at = AT_LENGTH;
					field_left = '0;
					bitlen_acc = '0;
				end
			end
			AT_LENGTH: begin
				bitlen_acc = {bitlen_acc[23:0], b};
				field_left = field_left + 29'd1;
				if (field_left >= FIELD_BYTES) begin
					len = bitlen_acc[31:3];
					res.kind = aftp_pkg::KIND_HEADER;
					res.tag_name = name_acc;
					res.tag_length = len;
					res.tag_end = (len == '0);
					step_out.push_back(res);
					if (len == '0) begin
						parse_at = AT_NAME;
						field_left = '0;
						name_acc = '0;
					end else begin
						parse_at = AT_PAYLOAD;
						field_left = len;
					end
				end
			end
			AT_PAYLOAD: begin
				res.kind = aftp_pkg::KIND_PAYLOAD;
				res.tag_name = name_acc;
				res.tag_length = bitlen_acc[31:3];
				res.payload_byte = b;
				res.tag_end = (field_left <= 29'd1);
				step_out.push_back(res);
				if (field_left <= 29'd1) begin
					parse_at = AT_NAME;
					field_left = '0;
					name_acc = '0;
				end else begin
					field_left = field_left - 29'd1;
				end
			end
			default: begin
			end
			endcase
		end
		if (in_last) begin
			res = '0;
			res.kind = aftp_pkg::KIND_STATUS;
			if (error_cap != aftp_pkg::ST_OK)
				res.status = error_cap;
			else if (parse_at == AT_HEADER)
				res.status = aftp_pkg::ST_TOO_SHORT;
			else if (parse_at == AT_NAME && field_left == '0)
				res.status = aftp_pkg::ST_OK;
			else
				res.status = aftp_pkg::ST_TRUNCATED;
			res.sequence_res = seq_cap;
			res.header_flags = flags_cap;
			step_out.push_back(res);
			clear_frame_state();
		end
		for (i = 0; i < step_out.size(); i++) begin
			res = step_out[i];
			res.final_of_step = (i == step_out.size() - 1);
			expected_results.push_back(res);
		end
	endtask

	task automatic check_field(input string field_name, input logic [31:0] want,
	                           input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", field_name, want, got);
			mismatch_count++;
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			byte_taken <= 1'b0;
		end else begin
			byte_taken <= frame_ch.valid && frame_ch.ready;
			if (frame_ch.valid && frame_ch.ready)
				parse_frame_byte(frame_ch.data_byte, frame_ch.frame_end);
			if (result_ch.valid && result_ch.ready) begin
				seen_res.kind = result_ch.kind;
				seen_res.tag_name = result_ch.tag_name;
				seen_res.tag_length = result_ch.tag_length;
				seen_res.payload_byte = result_ch.payload_byte;
				seen_res.tag_end = result_ch.tag_end;
				seen_res.status = result_ch.status;
				seen_res.sequence_res = result_ch.sequence_res;
				seen_res.header_flags = result_ch.header_flags;
				seen_res.final_of_step = result_ch.final_of_step;
				if (expected_results.size() == 0) begin
					$error("result transfer with nothing expected, kind %0d", seen_res.kind);
					mismatch_count++;
				end else begin
					want_res = expected_results.pop_front();
					check_field("kind", 32'(want_res.kind), 32'(seen_res.kind));
					check_field("tag_name", want_res.tag_name, seen_res.tag_name);
					check_field("tag_length", 32'(want_res.tag_length),
					            32'(seen_res.tag_length));
					check_field("payload_byte", 32'(want_res.payload_byte),
					            32'(seen_res.payload_byte));
					check_field("tag_end", 32'(want_res.tag_end), 32'(seen_res.tag_end));
					check_field("status", 32'(want_res.status), 32'(seen_res.status));
					check_field("sequence_res", 32'(want_res.sequence_res),
					            32'(seen_res.sequence_res));
					check_field("header_flags", 32'(want_res.header_flags),
					            32'(seen_res.header_flags));
					check_field("final_of_step", 32'(want_res.final_of_step),
					            32'(seen_res.final_of_step));
				end
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			frame_ch.valid <= 1'b0;
			frame_ch.data_byte <= '0;
			frame_ch.frame_end <= 1'b0;
		end else if (!frame_ch.valid || byte_taken) begin
			if (pending_bytes.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
				next_byte = pending_bytes.pop_front();
				frame_ch.valid <= 1'b1;
				frame_ch.data_byte <= next_byte.data;
				frame_ch.frame_end <= next_byte.last;
			end else begin
				frame_ch.valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			hold_left <= 0;
			hold_seen_cnt <= 0;
		end else if (hold_seen_cnt != hold_req_cnt) begin
			hold_seen_cnt <= hold_req_cnt;
			hold_left <= LONG_HOLD;
			result_ch.ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic put_word(input logic [31:0] word);
		frame_buf.push_back(word[31:24]);
		frame_buf.push_back(word[23:16]);
		frame_buf.push_back(word[15:8]);
		frame_buf.push_back(word[7:0]);
	endtask

	task automatic put_header(input logic [15:0] seq, input logic [7:0] flags,
	                          input logic [7:0] proto);
		frame_buf.push_back(aftp_pkg::CHAR_A);
		frame_buf.push_back(aftp_pkg::CHAR_F);
		put_word($urandom());
		frame_buf.push_back(seq[15:8]);
		frame_buf.push_back(seq[7:0]);
		frame_buf.push_back(flags);
		frame_buf.push_back(proto);
	endtask

	task automatic put_item(input logic [31:0] name, input logic [31:0] bitlen,
	                        input int unsigned payload_bytes);
		put_word(name);
		put_word(bitlen);
		repeat (payload_bytes)
			frame_buf.push_back(8'($urandom_range(255)));
	endtask

	task automatic put_trailer();
		repeat (aftp_pkg::TRAILER_BYTES_DEF)
			frame_buf.push_back(8'($urandom_range(255)));
	endtask

	task automatic flush_frame();
		frame_byte_t fb;
		while (frame_buf.size() != 0) begin
			fb.data = frame_buf.pop_front();
			fb.last = (frame_buf.size() == 0);
			pending_bytes.push_back(fb);
			gen_count++;
		end
	endtask

	// Most frames are well formed; the rest are cut short, carry a broken
	// sync or type byte, or are plain noise.
	task automatic gen_random_frame();
		int unsigned flavor;
		int unsigned plen;
		int unsigned cut;
		logic [31:0] bitlen;
		flavor = $urandom_range(99);
		if (flavor >= 93) begin
			cut = $urandom_range(20, 1);
			repeat (cut)
				frame_buf.push_back(8'($urandom_range(255)));
		end else begin
			put_header(16'($urandom_range(16'hFFFF)), 8'($urandom_range(255)),
			           aftp_pkg::CHAR_T);
			repeat ($urandom_range(3)) begin
				plen = $urandom_range(6);
				bitlen = plen * 8 + $urandom_range(7);
				if ($urandom_range(19) == 0)
					bitlen = $urandom();
				put_item($urandom(), bitlen, plen);
			end
			put_trailer();
			if (flavor >= 85) begin
				case ($urandom_range(2))
				0: frame_buf[aftp_pkg::OFF_SYNC_A] = 8'($urandom_range(255));
				1: frame_buf[aftp_pkg::OFF_SYNC_F] = 8'($urandom_range(255));
				default: frame_buf[aftp_pkg::OFF_TYPE] = 8'($urandom_range(255));
				endcase
			end else if (flavor >= 70) begin
				cut = $urandom_range(frame_buf.size() - 1, 1);
				while (frame_buf.size() > cut)
					void'(frame_buf.pop_back());
			end
		end
		flush_frame();
	endtask

	task automatic run_random_frames(input int unsigned target);
		while (gen_count < target)
			gen_random_frame();
	endtask

	task automatic wait_drain();
		while (pending_bytes.size() != 0 || frame_ch.valid || expected_results.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		frame_ch.valid = 1'b0;
		frame_ch.data_byte = '0;
		frame_ch.frame_end = 1'b0;
		result_ch.ready = 1'b0;
		byte_taken = 1'b0;
		cycle_count = 0;
		mismatch_count = 0;
		gen_count = 0;
		hold_req_cnt = 0;
		src_idle_pct = 11;
		sink_idle_pct = 88;
		clear_frame_state();
		repeat (11) @(posedge clk);
		#1 arst_n = 1'b1;

		// Frames of one and two bytes never get past the trailer delay.
		frame_buf.push_back(aftp_pkg::CHAR_A);
		flush_frame();
		frame_buf.push_back(aftp_pkg::CHAR_A);
		frame_buf.push_back(aftp_pkg::CHAR_F);
		flush_frame();
		// Broken sync on the first byte, then on the second byte.
		put_word({8'h00, aftp_pkg::CHAR_F, 16'hFFFF});
		flush_frame();
		put_word({aftp_pkg::CHAR_A, 8'hB9, 16'h0000});
		flush_frame();
		put_header(16'h5AA5, 8'h81, 8'h55);
		put_trailer();
		flush_frame();
		// A clean frame with a one-byte item, an empty item and a two-byte item.
		put_header(16'h0000, 8'h00, aftp_pkg::CHAR_T);
		put_item({aftp_pkg::CHAR_T, 8'h45, 8'h53, aftp_pkg::CHAR_T}, 32'h0000_000F, 1);
		put_item(32'hFFFF_FFFF, 32'h0000_0007, 0);
		put_item(32'h0000_0000, 32'h0000_0010, 2);
		put_trailer();
		flush_frame();
		// The largest length ends in a truncated item.
		put_header(16'hFFFF, 8'hFF, aftp_pkg::CHAR_T);
		put_item($urandom(), 32'hFFFF_FFFF, 1);
		put_trailer();
		flush_frame();

		run_random_frames(PHASE_BYTES);
		wait_drain();

		src_idle_pct = 88;
		sink_idle_pct = 11;
		gen_count = 0;
		run_random_frames(PHASE_BYTES);
		wait_drain();

		src_idle_pct = 0;
		sink_idle_pct = 0;
		gen_count = 0;
		run_random_frames(PHASE_BYTES);
		hold_req_cnt++;
		wait_drain();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
